[rtl/tdm_pkg.sv]
// tdm_pkg: shared constants and types for the tile dedup map builder.
// No dependencies.
`timescale 1ns / 1ps
package tdm_pkg;
	localparam int MAX_UNIQUE_DEF   = 1024;
	localparam int MAX_MAP_SIDE_DEF = 128;
	localparam int ROWS_PER_TILE    = 8;
	localparam int ROW_W            = 64;
	localparam int ADDR_W           = 14;
	localparam int ENTRY_W          = 13;
	localparam int CNT_W            = 11;

	localparam logic [2:0] CFG_COLS    = 3'd0;
	localparam logic [2:0] CFG_ROWS    = 3'd1;
	localparam logic [2:0] CFG_LAYOUT  = 3'd2;
	localparam logic [2:0] CFG_MASK    = 3'd3;
	localparam logic [2:0] CFG_PALETTE = 3'd4;

	localparam logic [2:0] LAY_32X32   = 3'd0;
	localparam logic [2:0] LAY_64X32   = 3'd1;
	localparam logic [2:0] LAY_32X64   = 3'd2;
	localparam logic [2:0] LAY_64X64   = 3'd3;
	localparam logic [2:0] LAY_128     = 3'd4;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_SEARCH,
		ST_STORE,
		ST_RESULT
	} tdm_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  map_address;
		logic [ENTRY_W-1:0] map_entry;
		logic               is_new_tile;
		logic               blank_slot_needed;
		logic [CNT_W-1:0]   unique_count;
		logic               table_full;
		logic               frame_done;
	} tdm_result_t;
endpackage

[rtl/tile_dedup_map_builder.sv]
// Tile dedup map builder: collects 8x8 tiles row by row, dedups against a table.
// Rows 0..6 are buffered; the eighth row starts a table search over the single read
// port, one row per cycle, then a store if the tile is new and room is left, and a
// report; a blank tile skips the search, a frame's first tile is stored at once.
// Next-tile rows 0..6 may enter while a result waits; the eighth holds until it drains.
// Reset (arst_n low) clears control state and registers; memory needs no clear.
`timescale 1ns / 1ps
module tile_dedup_map_builder
	import tdm_pkg::*;
#(
	parameter int MAX_UNIQUE   = MAX_UNIQUE_DEF,
	parameter int MAX_MAP_SIDE = MAX_MAP_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ROW_W-1:0]   pixel_row,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ADDR_W-1:0]  map_address,
	output logic [ENTRY_W-1:0] map_entry,
	output logic               is_new_tile,
	output logic               blank_slot_needed,
	output logic [CNT_W-1:0]   unique_count,
	output logic               table_full,
	output logic               frame_done
);
	localparam int AW = $clog2(MAX_UNIQUE * ROWS_PER_TILE);
	localparam int SW = $clog2(MAX_UNIQUE);

	// configuration registers
	logic [7:0] cols_q, rows_q, mask_q;
	logic [2:0] layout_q;
	logic       keep_q;

	// control state
	tdm_state_t       state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             blank_miss_q;
	logic [2:0]       row_q;
	logic [6:0]       x_q, y_q;
	logic [2:0]       pal_q;
	logic             blank_q;
	logic [ROW_W-1:0] tile_q [ROWS_PER_TILE];
	logic             new_first_q, stored_q;

	// search: slot/row being issued, and the read in flight
	logic [SW-1:0]    slot_q;
	logic [2:0]       srow_q;
	logic             issue_done_q;
	logic             rd_vld_s1;
	logic [2:0]       rd_row_s1;
	logic [SW-1:0]    rd_slot_s1;
	logic             match_q;
	logic             found_q;
	logic [SW-1:0]    found_slot_q;

	tdm_result_t      res_q;
	logic             res_vld_q;

	logic [ROW_W-1:0] rdata, mask64, mrow;
	logic [AW-1:0]    raddr, waddr;
	logic             we;
	logic [ADDR_W-1:0] addr_w;

	assign mask64 = {8{mask_q}};
	assign mrow   = pixel_row & mask64;

	assign cfg_ready = 1'b1;
	// hold only the eighth row while a result waits; earlier rows may enter
	assign in_ready  = (state_q == ST_COLLECT) && !(res_vld_q && row_q == 3'd7);
	logic acc;
	assign acc = in_valid && in_ready;

	// row of the incoming item (frame_start forces row 0)
	logic [2:0] cur_row;
	assign cur_row = frame_start ? 3'd0 : row_q;

	assign raddr = {slot_q, srow_q};
	assign waddr = {count_q[SW-1:0], srow_q};
	assign we    = (state_q == ST_STORE);

	tdm_store #(.MAX_UNIQUE(MAX_UNIQUE)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(tile_q[srow_q]),
		.raddr(raddr),
		.rdata(rdata)
	);

	tdm_addr #(.MAX_MAP_SIDE(MAX_MAP_SIDE)) u_addr (
		.x     (x_q),
		.y     (y_q),
		.layout(layout_q),
		.addr  (addr_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= 8'd32;
			rows_q   <= 8'd32;
			layout_q <= LAY_32X32;
			mask_q   <= 8'hFF;
			keep_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COLS:    cols_q   <= cfg_data;
				CFG_ROWS:    rows_q   <= cfg_data;
				CFG_LAYOUT:  layout_q <= cfg_data[2:0];
				CFG_MASK:    mask_q   <= cfg_data;
				CFG_PALETTE: keep_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// next state
	logic last_row;
	assign last_row = (cur_row == 3'd7);
	logic nonblank_all;
	assign nonblank_all = !(blank_q && (mrow == '0));
	logic can_store;
	assign can_store = (12'(count_q) + 12'(blank_miss_q)) < 12'(MAX_UNIQUE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_COLLECT: if (acc && last_row) begin
				if (frame_start || count_q == '0)
					state_d = ST_STORE;
				else if (nonblank_all)
					state_d = ST_SEARCH;
				else
					state_d = ST_RESULT;
			end
			ST_SEARCH: if (found_q || (issue_done_q && !rd_vld_s1 && !match_q))
				state_d = (found_q || !can_store) ? ST_RESULT : ST_STORE;
			ST_STORE: if (srow_q == 3'd7) state_d = ST_RESULT;
			ST_RESULT: state_d = ST_COLLECT;
			default: state_d = ST_COLLECT;
		endcase
	end

	// tile number and result fields
	logic [CNT_W-1:0] tnum;
	logic             is_new, full;
	always_comb begin
		is_new = 1'b0;
		full   = 1'b0;
		tnum   = '0;
		if (blank_q && !new_first_q) begin
			tnum = '0;
		end else if (new_first_q) begin
			tnum   = CNT_W'(blank_miss_q);
			is_new = 1'b1;
		end else if (found_q) begin
			tnum = CNT_W'(found_slot_q) + CNT_W'(blank_miss_q);
		end else if (stored_q) begin
			tnum   = count_q - 1'b1 + CNT_W'(blank_miss_q);
			is_new = 1'b1;
		end else begin
			full = 1'b1;
		end
	end

	logic wrap_x, wrap_y;
	assign wrap_x = (8'(x_q) + 8'd1 >= cols_q) || (x_q >= 7'd127);
	assign wrap_y = (8'(y_q) + 8'd1 >= rows_q) || (y_q >= 7'd127);

	always_ff @(posedge clk) begin
		if (acc)
			tile_q[cur_row] <= mrow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_COLLECT;
			count_q      <= '0;
			blank_miss_q <= 1'b0;
			row_q        <= '0;
			x_q          <= '0;
			y_q          <= '0;
			pal_q        <= '0;
			blank_q      <= 1'b1;
			slot_q       <= '0;
			srow_q       <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_row_s1    <= '0;
			rd_slot_s1   <= '0;
			match_q      <= 1'b1;
			found_q      <= 1'b0;
			found_slot_q <= '0;
			new_first_q  <= 1'b0;
			stored_q     <= 1'b0;
			res_vld_q    <= 1'b0;
			res_q        <= '0;
		end else begin
			state_q <= state_d;
			if (res_vld_q && out_ready)
				res_vld_q <= 1'b0;
			unique case (state_q)
				ST_COLLECT: if (acc) begin
					if (frame_start) begin
						count_q      <= '0;
						blank_miss_q <= 1'b0;
						x_q          <= '0;
						y_q          <= '0;
					end
					if (cur_row == 3'd0) begin
						pal_q   <= pixel_row[6:4];
						blank_q <= (mrow == '0);
					end else if (mrow != '0) begin
						blank_q <= 1'b0;
					end
					row_q        <= cur_row + 3'd1;
					slot_q       <= '0;
					srow_q       <= '0;
					issue_done_q <= 1'b0;
					rd_vld_s1    <= 1'b0;
					match_q      <= 1'b1;
					found_q      <= 1'b0;
					stored_q     <= 1'b0;
					new_first_q  <= last_row && (frame_start || count_q == '0);
					if (last_row && (frame_start || count_q == '0)) begin
						blank_miss_q <= !((cur_row == 3'd0 ? 1'b1 : blank_q) && mrow == '0);
						count_q      <= '0;
					end
				end
				ST_SEARCH: begin
					// issue one row read per cycle
					rd_vld_s1  <= !issue_done_q && !found_q;
					rd_row_s1  <= srow_q;
					rd_slot_s1 <= slot_q;
					if (!issue_done_q && !found_q) begin
						srow_q <= srow_q + 3'd1;
						if (srow_q == 3'd7) begin
							if (CNT_W'(slot_q) + 1'b1 >= count_q ||
								32'(slot_q) == MAX_UNIQUE - 1)
								issue_done_q <= 1'b1;
							else
								slot_q <= slot_q + 1'b1;
						end
					end
					// compare the returned row; row 0 opens a fresh slot
					if (rd_vld_s1 && !found_q) begin
						if (rd_row_s1 == 3'd7) begin
							if (match_q && rdata == tile_q[rd_row_s1]) begin
								found_q      <= 1'b1;
								found_slot_q <= rd_slot_s1;
							end
							match_q <= 1'b1;
						end else begin
							match_q <= ((rd_row_s1 == 3'd0) || match_q) &&
								(rdata == tile_q[rd_row_s1]);
						end
					end else if (!rd_vld_s1) begin
						match_q <= 1'b0;
					end
					if (state_d == ST_STORE)
						srow_q <= '0;
				end
				ST_STORE: begin
					srow_q <= srow_q + 3'd1;
					if (srow_q == 3'd7) begin
						count_q  <= count_q + 1'b1;
						stored_q <= 1'b1;
					end
				end
				ST_RESULT: begin
					res_vld_q               <= 1'b1;
					res_q.map_address       <= addr_w;
					res_q.map_entry         <= {(keep_q ? pal_q : 3'd0), tnum[9:0]};
					res_q.is_new_tile       <= is_new;
					res_q.blank_slot_needed <= blank_miss_q;
					res_q.unique_count      <= count_q;
					res_q.table_full        <= full;
					res_q.frame_done        <= wrap_x && wrap_y;
					row_q <= '0;
					if (wrap_x) begin
						x_q <= '0;
						y_q <= wrap_y ? 7'd0 : y_q + 7'd1;
					end else begin
						x_q <= x_q + 7'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid         = res_vld_q;
	assign map_address       = res_q.map_address;
	assign map_entry         = res_q.map_entry;
	assign is_new_tile       = res_q.is_new_tile;
	assign blank_slot_needed = res_q.blank_slot_needed;
	assign unique_count      = res_q.unique_count;
	assign table_full        = res_q.table_full;
	assign frame_done        = res_q.frame_done;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COLLECT) |-> !in_ready) else $error("accept while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_UNIQUE) else $error("count overflow");
	a_store_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE && srow_q != 3'd7) |=> state_q == ST_STORE)
		else $error("store cut short");
endmodule

[rtl/tdm_addr.sv]
// tdm_addr: tile map word address for the selected layout.
// Depends on tdm_pkg.
`timescale 1ns / 1ps
module tdm_addr
	import tdm_pkg::*;
#(
	parameter int MAX_MAP_SIDE = MAX_MAP_SIDE_DEF
) (
	input  logic [6:0]        x,
	input  logic [6:0]        y,
	input  logic [2:0]        layout,
	output logic [ADDR_W-1:0] addr
);
	logic [17:0] a;
	logic [17:0] xx, yy;
	always_comb begin
		xx = {11'd0, x};
		yy = {11'd0, y};
		unique case (layout)
			LAY_64X32: a = (x < 7'd32) ? (yy * 18'd32 + xx)
				: ((yy + 18'd32) * 18'd32 + xx - 18'd32);
			LAY_32X64: a = yy * 18'd32 + xx;
			LAY_64X64: begin
				if (y < 7'd32)
					a = (x < 7'd32) ? (yy * 18'd32 + xx)
						: ((yy + 18'd32) * 18'd32 + xx - 18'd32);
				else
					a = (x < 7'd32) ? ((yy + 18'd32) * 18'd32 + xx)
						: ((yy + 18'd64) * 18'd32 + xx - 18'd32);
			end
			LAY_128: a = yy * 18'(MAX_MAP_SIDE) + xx;
			default: a = yy * 18'd32 + xx;
		endcase
		addr = a[ADDR_W-1:0];
	end
endmodule

[rtl/tdm_store.sv]
// tdm_store: unique tile memory, one 64-bit row per word, registered read.
// Depends on tdm_pkg.
`timescale 1ns / 1ps
module tdm_store
	import tdm_pkg::*;
#(
	parameter int MAX_UNIQUE = MAX_UNIQUE_DEF,
	localparam int AW = $clog2(MAX_UNIQUE * ROWS_PER_TILE)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [ROW_W-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [ROW_W-1:0] rdata
);
	logic [ROW_W-1:0] mem [MAX_UNIQUE*ROWS_PER_TILE];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[tb/tdm_checker.sv]
// tdm_checker: watches the config, row and result channels of the tile dedup map builder,
// predicts every tile result and compares it field by field.
// Depends on tdm_pkg.
`timescale 1ns / 1ps
module tdm_checker
	import tdm_pkg::*;
#(
	parameter int MAX_UNIQUE   = MAX_UNIQUE_DEF,
	parameter int MAX_MAP_SIDE = MAX_MAP_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [ROW_W-1:0]   pixel_row,
	input  logic               frame_start,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [ADDR_W-1:0]  map_address,
	input  logic [ENTRY_W-1:0] map_entry,
	input  logic               is_new_tile,
	input  logic               blank_slot_needed,
	input  logic [CNT_W-1:0]   unique_count,
	input  logic               table_full,
	input  logic               frame_done,
	output int                 errors,
	output int                 pending
);
	logic [63:0] known_tiles [MAX_UNIQUE*8];
	logic [63:0] tile_buf [8];
	int unsigned n_known = 0;
	bit          blank_owed = 0;
	logic [2:0]  row_idx = 3'd0;
	int unsigned pos_x = 0, pos_y = 0;
	logic [2:0]  pal = 3'd0;

	logic [7:0] c_cols = 8'd32, c_rows = 8'd32, c_mask = 8'hFF;
	logic [2:0] c_layout = LAY_32X32;
	logic       c_pal = 1'b0;

	tdm_result_t tile_results_q[$];
	int err_cnt = 0;

	assign errors  = err_cnt;
	assign pending = tile_results_q.size();

	task automatic flag(input string what);
		$display("%0t ns tile result mismatch: %s", $time, what);
		err_cnt++;
	endtask

	function automatic logic [ADDR_W-1:0] map_word(input int unsigned x, input int unsigned y);
		int unsigned a;
		case (c_layout)
			LAY_64X32: a = (x < 32) ? y*32 + x : (y+32)*32 + x - 32;
			LAY_32X64: a = y*32 + x;
			LAY_64X64: begin
				if (y < 32)
					a = (x < 32) ? y*32 + x : (y+32)*32 + x - 32;
				else
					a = (x < 32) ? (y+32)*32 + x : (y+64)*32 + x - 32;
			end
			LAY_128:   a = y*MAX_MAP_SIDE + x;
			default:   a = y*32 + x;
		endcase
		return a[ADDR_W-1:0];
	endfunction

	function automatic bit tile_matches(input int unsigned slot);
		for (int r = 0; r < 8; r++)
			if (known_tiles[slot*8 + r] !== tile_buf[r])
				return 0;
		return 1;
	endfunction

	task automatic keep_tile(input int unsigned slot);
		for (int r = 0; r < 8; r++)
			known_tiles[slot*8 + r] = tile_buf[r];
	endtask

	// Absorb one row; on the eighth row dedup the tile and queue its expected result.
	task automatic absorb_row(input logic [63:0] row, input logic fs);
		bit          blank;
		bit          hit;
		int unsigned num;
		int unsigned slot;
		tdm_result_t res;
		if (fs) begin
			n_known    = 0;
			blank_owed = 0;
			row_idx    = 0;
			pos_x      = 0;
			pos_y      = 0;
		end
		if (row_idx == 0)
			pal = row[6:4];
		tile_buf[row_idx] = row & {8{c_mask}};
		if (row_idx != 3'd7) begin
			row_idx++;
			return;
		end
		row_idx = 0;
		blank = 1;
		for (int r = 0; r < 8; r++)
			if (tile_buf[r] != 64'd0)
				blank = 0;
		res = '0;
		num = 0;
		if (n_known == 0) begin
			blank_owed = !blank;
			keep_tile(0);
			n_known = 1;
			num = blank_owed;
			res.is_new_tile = 1'b1;
		end else if (!blank) begin
			hit = 0;
			for (slot = 0; slot < n_known && slot < MAX_UNIQUE; slot++)
				if (tile_matches(slot)) begin
					hit = 1;
					break;
				end
			if (hit)
				num = slot + blank_owed;
			else if (n_known + blank_owed < MAX_UNIQUE) begin
				keep_tile(n_known);
				num = n_known + blank_owed;
				n_known++;
				res.is_new_tile = 1'b1;
			end else
				res.table_full = 1'b1;
		end
		res.map_address = map_word(pos_x, pos_y);
		res.map_entry   = {(c_pal ? pal : 3'd0), num[9:0]};
		// Advance the raster position; zero columns or rows act as one.
		if (pos_x + 1 >= c_cols || pos_x >= 127) begin
			pos_x = 0;
			if (pos_y + 1 >= c_rows || pos_y >= 127) begin
				pos_y = 0;
				res.frame_done = 1'b1;
			end else
				pos_y++;
		end else
			pos_x++;
		res.blank_slot_needed = blank_owed;
		res.unique_count      = n_known[CNT_W-1:0];
		tile_results_q.push_back(res);
	endtask

	always @(posedge clk) begin
		tdm_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COLS:    c_cols   = cfg_data;
					CFG_ROWS:    c_rows   = cfg_data;
					CFG_LAYOUT:  c_layout = cfg_data[2:0];
					CFG_MASK:    c_mask   = cfg_data;
					CFG_PALETTE: c_pal    = cfg_data[0];
					default:     ;
				endcase
			end
			if (in_valid && in_ready)
				absorb_row(pixel_row, frame_start);
			if (out_valid && out_ready) begin
				if (tile_results_q.size() == 0)
					flag("result with none expected");
				else begin
					want = tile_results_q.pop_front();
					if (map_address !== want.map_address)
						flag($sformatf("map_address %0d want %0d", map_address, want.map_address));
					if (map_entry !== want.map_entry)
						flag($sformatf("map_entry %h want %h", map_entry, want.map_entry));
					if (is_new_tile !== want.is_new_tile)
						flag($sformatf("is_new_tile %b want %b", is_new_tile, want.is_new_tile));
					if (blank_slot_needed !== want.blank_slot_needed)
						flag($sformatf("blank_slot_needed %b want %b", blank_slot_needed,
							want.blank_slot_needed));
					if (unique_count !== want.unique_count)
						flag($sformatf("unique_count %0d want %0d", unique_count,
							want.unique_count));
					if (table_full !== want.table_full)
						flag($sformatf("table_full %b want %b", table_full, want.table_full));
					if (frame_done !== want.frame_done)
						flag($sformatf("frame_done %b want %b", frame_done, want.frame_done));
				end
			end
		end
	end
endmodule

[tb/tb_top.sv]
// tb_top: stimulus and verdict for the tile dedup map builder, checked by tdm_checker.
// Depends on tdm_pkg, tile_dedup_map_builder and tdm_checker.
`timescale 1ns / 1ps
module tb_top;
	import tdm_pkg::*;

	// Small table so that the full-table case is reached within a short run.
	localparam int TB_MAX_UNIQUE = 16;
	localparam int DRAIN_CYCLES  = 200;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = CFG_COLS;
	logic [7:0]         cfg_data = 8'd0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [ROW_W-1:0]   pixel_row = '0;
	logic               frame_start = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [ADDR_W-1:0]  map_address;
	logic [ENTRY_W-1:0] map_entry;
	logic               is_new_tile;
	logic               blank_slot_needed;
	logic [CNT_W-1:0]   unique_count;
	logic               table_full;
	logic               frame_done;
	int                 errors;
	int                 pending;

	// Idle percentages of the row sender and the result receiver.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// Pool of raw tiles that recur, so that dedup hits are frequent.
	logic [63:0] tile_pool [8][8];

	always #6 clk = ~clk;

	tile_dedup_map_builder #(.MAX_UNIQUE(TB_MAX_UNIQUE)) u_dut (.*);

	tdm_checker #(.MAX_UNIQUE(TB_MAX_UNIQUE)) u_chk (.*);

	// Stall the result channel at random.
	always @(posedge clk)
		out_ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);

	// Send one row transaction; hold valid and payload until accepted.
	task automatic send_row(input logic [63:0] row, input logic fs);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_row   <= row;
		frame_start <= fs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every pending tile result, then let the search settle.
	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Send one tile of eight rows; kind: 0 blank, 1 pooled, 2 fresh, 3 sparse.
	task automatic send_tile(input int kind, input logic first_fs, input bit noisy);
		logic [63:0] rows [8];
		int          pick;
		logic        fs;
		pick = $urandom_range(0, 7);
		for (int r = 0; r < 8; r++) begin
			case (kind)
				0:       rows[r] = 64'd0;
				1:       rows[r] = tile_pool[pick][r];
				2:       rows[r] = {$urandom, $urandom};
				default: rows[r] = 64'd1 << $urandom_range(0, 63);
			endcase
		end
		if (kind == 2 && $urandom_range(0, 3) == 0)
			tile_pool[pick] = rows;
		for (int r = 0; r < 8; r++) begin
			fs = (r == 0) ? first_fs : 1'b0;
			// Hit a frame start in the middle of a tile now and then.
			if (noisy && $urandom_range(0, 99) < 2)
				fs = 1'b1;
			send_row(rows[r], fs);
		end
	endtask

	initial begin
		logic [7:0] cols, rws, msk;
		logic [2:0] lay;
		logic       palf;
		int         ntiles;
		for (int p = 0; p < 8; p++)
			for (int r = 0; r < 8; r++)
				tile_pool[p][r] = {$urandom, $urandom};
		tile_pool[0] = '{default: 64'hFFFF_FFFF_FFFF_FFFF};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: non-blank pooled first tile, then a blank tile, then the all-ones pooled tile.
		send_tile(1'b0 ? 0 : 1, 1'b1, 0);
		send_tile(0, 1'b0, 0);
		send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		for (int r = 1; r < 8; r++)
			send_row(tile_pool[0][r], 1'b0);
		drain();

		for (int p = 0; p < 10; p++) begin
			send_idle_pct  = (p < 4) ? 27 : (p < 7) ? 76 : 0;
			recv_stall_pct = (p < 4) ? 76 : (p < 7) ? 27 : 0;
			ntiles = 4;
			case (p)
				0: begin
					cols = 8'd1; rws = 8'd1; lay = LAY_32X32; msk = 8'hFF; palf = 1'b1;
				end
				1: begin
					cols = 8'd3; rws = 8'd1; lay = LAY_128; msk = 8'h0F; palf = 1'b0;
				end
				2: begin
					cols = 8'd0; rws = 8'd0; lay = 3'd7; msk = 8'h00; palf = 1'b1;
				end
				3: begin
					cols = 8'd200; rws = 8'd3; lay = LAY_64X32; msk = 8'hF0; palf = 1'b0;
				end
				4: begin
					cols = 8'd40; rws = 8'd2; lay = LAY_64X64; msk = 8'h81; palf = 1'b1;
				end
				5: begin
					cols = 8'd1; rws = 8'd34; lay = LAY_64X64; msk = 8'hFF; palf = 1'b1;
					ntiles = 34;
				end
				6: begin
					cols = 8'd33; rws = 8'd5; lay = LAY_32X64; msk = 8'h7F; palf = 1'b0;
				end
				default: begin
					cols = 8'($urandom_range(0, 255));
					rws  = 8'($urandom_range(0, 255));
					lay  = 3'($urandom_range(0, 7));
					msk  = 8'($urandom_range(0, 255));
					palf = 1'($urandom_range(0, 1));
				end
			endcase
			write_reg(CFG_COLS, cols);
			write_reg(CFG_ROWS, rws);
			write_reg(CFG_LAYOUT, {5'd0, lay});
			write_reg(CFG_MASK, msk);
			write_reg(CFG_PALETTE, {7'd0, palf});
			// An unused index must be ignored.
			if (p == 0)
				write_reg(3'd5, 8'hFF);
			// Open each frame with a frame start; alternate blank and non-blank first tiles.
			send_tile((p % 2) ? 0 : 2, 1'b1, 0);
			for (int t = 1; t < ntiles; t++)
				send_tile($urandom_range(0, 3), ($urandom_range(0, 99) < 4), 1);
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(12 * 2000000);
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
